FILE: rtl/segment_pair_intersection_classify_core_assert.svh
// Assertion macros for the segment pair classifier checker.
// Needs clk and rst in scope where used; no other dependencies.
`ifndef SEGMENT_PAIR_INTERSECTION_CLASSIFY_CORE_ASSERT_SVH
`define SEGMENT_PAIR_INTERSECTION_CLASSIFY_CORE_ASSERT_SVH

// same-cycle implication, off while reset is high
`define SPIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, active during reset too
`define SPIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/spic_pkg.sv
// Shared types, widths, codes and helper functions for the segment pair classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spic_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int HPX_W   = CROSS_W + COORD_W;
  localparam int HPD_W   = CROSS_W + DIFF_W;
  localparam int NUM_W   = HPD_W + 1;
  localparam int QUO_W   = COORD_W + 1;
  localparam int LIM_W   = 16;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1);
  localparam logic [PADDR_W-3:0] REG_NEAR_ZERO_LIMIT = '0;

  localparam logic [2:0] REL_IDENTICAL  = 3'd0;
  localparam logic [2:0] REL_CONTAINING = 3'd1;
  localparam logic [2:0] REL_CONTAINED  = 3'd2;
  localparam logic [2:0] REL_NONE       = 3'd3;
  localparam logic [2:0] REL_HIT        = 3'd4;
  localparam logic [2:0] REL_OVERLAP    = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_start_x;
    logic signed [COORD_W-1:0] a_start_y;
    logic signed [COORD_W-1:0] a_end_x;
    logic signed [COORD_W-1:0] a_end_y;
    logic signed [COORD_W-1:0] b_start_x;
    logic signed [COORD_W-1:0] b_start_y;
    logic signed [COORD_W-1:0] b_end_x;
    logic signed [COORD_W-1:0] b_end_y;
  } seg_t;

  typedef struct packed {
    logic [2:0]                relation;
    logic signed [COORD_W-1:0] cross_x;
    logic signed [COORD_W-1:0] cross_y;
  } res_t;

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic logic [DIFF_W-1:0] mag_d(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  function automatic logic [CROSS_W-1:0] mag_c(input logic signed [CROSS_W-1:0] v);
    return v[CROSS_W-1] ? CROSS_W'(-v) : CROSS_W'(v);
  endfunction

  function automatic logic is_small(input logic signed [CROSS_W-1:0] v,
                                    input logic [LIM_W-1:0] lim);
    return mag_c(v) < CROSS_W'(lim);
  endfunction

  // n/d within [0,1] without dividing
  function automatic logic unit_d(input logic signed [DIFF_W-1:0] n,
                                  input logic signed [DIFF_W-1:0] d);
    return (n == '0) || ((n[DIFF_W-1] == d[DIFF_W-1]) && (mag_d(n) <= mag_d(d)));
  endfunction

  function automatic logic unit_c(input logic signed [CROSS_W-1:0] n,
                                  input logic signed [CROSS_W-1:0] d);
    return (n == '0) || ((n[CROSS_W-1] == d[CROSS_W-1]) && (mag_c(n) <= mag_c(d)));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/segment_pair_intersection_classify_core.sv
// Throughput one request per cycle while the output is not stalled (res_stall low).
// Depth is set by the 17-stage restoring divider (one quotient bit per stage) behind
// six arithmetic stages; each stage advances on its own, so bubbles close under stall.
// Reset (rst, synchronous, active high) empties the pipeline and sets near_zero_limit to 1.
// Uses spic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module segment_pair_intersection_classify_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [spic_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [spic_pkg::PDATA_W-1:0]  pwdata,
  output logic      [spic_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          seg_valid,
  output logic                               seg_stall,
  input  wire spic_pkg::seg_t                seg,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output spic_pkg::res_t                     res
);

  localparam int CW = spic_pkg::COORD_W;
  localparam int DW = spic_pkg::DIFF_W;
  localparam int PW = spic_pkg::PROD_W;
  localparam int XW = spic_pkg::CROSS_W;
  localparam int NW = spic_pkg::NUM_W;
  localparam int QW = spic_pkg::QUO_W;
  localparam int LW = spic_pkg::LIM_W;

  localparam int S_DIFF  = 0;
  localparam int S_PROD  = 1;
  localparam int S_CROSS = 2;
  localparam int S_CLASS = 3;
  localparam int S_SUM   = 4;
  localparam int S_ABS   = 5;
  localparam int S_DIV   = 6;
  localparam int S_OUT   = S_DIV + QW;
  localparam int NS      = S_OUT + 1;

  // ---------------- configuration ----------------
  logic [LW-1:0] limit;
  logic [LW-1:0] lim;
  logic          reg_hit;

  assign reg_hit = (paddr[spic_pkg::PADDR_W-1:2] == spic_pkg::REG_NEAR_ZERO_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? spic_pkg::PDATA_W'(limit) : '0;
  assign lim     = (limit == '0) ? LW'(1) : limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= spic_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      limit <= pwdata[LW-1:0];
    end
  end

  // ---------------- flow control ----------------
  logic [NS-1:0] v;
  logic [NS:0]   en;

  always_comb begin
    en[NS] = !res_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign seg_stall = !en[0];
  assign res_valid = v[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= seg_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // ---------------- stage 1: differences ----------------
  spic_pkg::seg_t        s1_seg;
  logic signed [DW-1:0]  s1_ax, s1_ay, s1_bx, s1_by, s1_ox, s1_oy;
  logic signed [DW-1:0]  s1_pdx [4];
  logic signed [DW-1:0]  s1_pdy [4];

  always_ff @(posedge clk) begin
    if (en[S_DIFF]) begin
      s1_seg    <= seg;
      s1_ax     <= spic_pkg::sdiff(seg.a_end_x, seg.a_start_x);
      s1_ay     <= spic_pkg::sdiff(seg.a_end_y, seg.a_start_y);
      s1_bx     <= spic_pkg::sdiff(seg.b_end_x, seg.b_start_x);
      s1_by     <= spic_pkg::sdiff(seg.b_end_y, seg.b_start_y);
      s1_ox     <= spic_pkg::sdiff(seg.a_start_x, seg.b_start_x);
      s1_oy     <= spic_pkg::sdiff(seg.a_start_y, seg.b_start_y);
      // point-on-segment offsets: B start / B end against A, A start / A end against B
      s1_pdx[0] <= spic_pkg::sdiff(seg.b_start_x, seg.a_start_x);
      s1_pdy[0] <= spic_pkg::sdiff(seg.b_start_y, seg.a_start_y);
      s1_pdx[1] <= spic_pkg::sdiff(seg.b_end_x, seg.a_start_x);
      s1_pdy[1] <= spic_pkg::sdiff(seg.b_end_y, seg.a_start_y);
      s1_pdx[2] <= spic_pkg::sdiff(seg.a_start_x, seg.b_start_x);
      s1_pdy[2] <= spic_pkg::sdiff(seg.a_start_y, seg.b_start_y);
      s1_pdx[3] <= spic_pkg::sdiff(seg.a_end_x, seg.b_start_x);
      s1_pdy[3] <= spic_pkg::sdiff(seg.a_end_y, seg.b_start_y);
    end
  end

  // ---------------- stage 2: products and point flags ----------------
  logic signed [PW-1:0] s2_den1, s2_den2, s2_na1, s2_na2, s2_nb1, s2_nb2;
  logic signed [PW-1:0] s2_lt1 [4];
  logic signed [PW-1:0] s2_lt2 [4];
  logic [3:0]           s2_bigx, s2_ukx, s2_bigy, s2_uky;
  logic                 s2_ss, s2_sb, s2_es, s2_ee;
  logic signed [CW-1:0] s2_asx, s2_asy, s2_aex, s2_aey;
  logic signed [DW-1:0] s2_ax, s2_ay;

  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      s2_den1 <= PW'(s1_by) * PW'(s1_ax);
      s2_den2 <= PW'(s1_bx) * PW'(s1_ay);
      s2_na1  <= PW'(s1_bx) * PW'(s1_oy);
      s2_na2  <= PW'(s1_by) * PW'(s1_ox);
      s2_nb1  <= PW'(s1_ax) * PW'(s1_oy);
      s2_nb2  <= PW'(s1_ay) * PW'(s1_ox);
      for (int k = 0; k < 4; k++) begin
        s2_lt1[k]  <= PW'(s1_pdx[k]) * PW'((k < 2) ? s1_ay : s1_by);
        s2_lt2[k]  <= PW'(s1_pdy[k]) * PW'((k < 2) ? s1_ax : s1_bx);
        s2_bigx[k] <= spic_pkg::mag_d((k < 2) ? s1_ax : s1_bx) > DW'(lim);
        s2_bigy[k] <= spic_pkg::mag_d((k < 2) ? s1_ay : s1_by) > DW'(lim);
        s2_ukx[k]  <= spic_pkg::unit_d(s1_pdx[k], (k < 2) ? s1_ax : s1_bx);
        s2_uky[k]  <= spic_pkg::unit_d(s1_pdy[k], (k < 2) ? s1_ay : s1_by);
      end
      s2_ss  <= (s1_seg.a_start_x == s1_seg.b_start_x) && (s1_seg.a_start_y == s1_seg.b_start_y);
      s2_sb  <= (s1_seg.a_start_x == s1_seg.b_end_x) && (s1_seg.a_start_y == s1_seg.b_end_y);
      s2_es  <= (s1_seg.a_end_x == s1_seg.b_start_x) && (s1_seg.a_end_y == s1_seg.b_start_y);
      s2_ee  <= (s1_seg.a_end_x == s1_seg.b_end_x) && (s1_seg.a_end_y == s1_seg.b_end_y);
      s2_asx <= s1_seg.a_start_x;
      s2_asy <= s1_seg.a_start_y;
      s2_aex <= s1_seg.a_end_x;
      s2_aey <= s1_seg.a_end_y;
      s2_ax  <= s1_ax;
      s2_ay  <= s1_ay;
    end
  end

  // ---------------- stage 3: cross products ----------------
  logic signed [XW-1:0] s3_den, s3_na, s3_nb;
  logic signed [XW-1:0] s3_lt [4];
  logic [3:0]           s3_bigx, s3_ukx, s3_bigy, s3_uky;
  logic                 s3_ss, s3_sb, s3_es, s3_ee;
  logic signed [CW-1:0] s3_asx, s3_asy, s3_aex, s3_aey;
  logic signed [DW-1:0] s3_ax, s3_ay;

  always_ff @(posedge clk) begin
    if (en[S_CROSS]) begin
      s3_den <= XW'(s2_den1) - XW'(s2_den2);
      s3_na  <= XW'(s2_na1) - XW'(s2_na2);
      s3_nb  <= XW'(s2_nb1) - XW'(s2_nb2);
      for (int k = 0; k < 4; k++) begin
        s3_lt[k] <= XW'(s2_lt1[k]) - XW'(s2_lt2[k]);
      end
      s3_bigx <= s2_bigx;
      s3_ukx  <= s2_ukx;
      s3_bigy <= s2_bigy;
      s3_uky  <= s2_uky;
      s3_ss   <= s2_ss;
      s3_sb   <= s2_sb;
      s3_es   <= s2_es;
      s3_ee   <= s2_ee;
      s3_asx  <= s2_asx;
      s3_asy  <= s2_asy;
      s3_aex  <= s2_aex;
      s3_aey  <= s2_aey;
      s3_ax   <= s2_ax;
      s3_ay   <= s2_ay;
    end
  end

  // ---------------- stage 4: classify, hit-point products ----------------
  logic [3:0]           on_seg;
  logic [3:0]           pt_eq;
  logic                 den_small, collinear;
  logic [2:0]           rel_c;
  logic                 div_c;
  logic signed [CW-1:0] ptx_c, pty_c;

  assign pt_eq = {s3_es, s3_ss, s3_sb, s3_ss};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      on_seg[k] = spic_pkg::is_small(s3_lt[k], lim) &&
                  (s3_bigx[k] ? s3_ukx[k] : (s3_bigy[k] ? s3_uky[k] : pt_eq[k]));
    end
    den_small = spic_pkg::is_small(s3_den, lim);
    collinear = den_small && spic_pkg::is_small(s3_na, lim) && spic_pkg::is_small(s3_nb, lim);
    rel_c = spic_pkg::REL_NONE;
    div_c = 1'b0;
    ptx_c = '0;
    pty_c = '0;
    if (den_small) begin
      if (collinear) begin
        if ((s3_ss && s3_ee) || (s3_sb && s3_es)) begin
          rel_c = spic_pkg::REL_IDENTICAL;
        end else if (on_seg[0] && on_seg[1]) begin
          rel_c = spic_pkg::REL_CONTAINING;
        end else if (on_seg[2] && on_seg[3]) begin
          rel_c = spic_pkg::REL_CONTAINED;
        end else if (!on_seg[0] && !on_seg[1]) begin
          rel_c = spic_pkg::REL_NONE;
        end else if (s3_ss || s3_sb) begin
          rel_c = spic_pkg::REL_HIT;
          ptx_c = s3_asx;
          pty_c = s3_asy;
        end else if (s3_ee || s3_es) begin
          rel_c = spic_pkg::REL_HIT;
          ptx_c = s3_aex;
          pty_c = s3_aey;
        end else begin
          rel_c = spic_pkg::REL_OVERLAP;
        end
      end
    end else if (spic_pkg::unit_c(s3_na, s3_den) && spic_pkg::unit_c(s3_nb, s3_den)) begin
      rel_c = spic_pkg::REL_HIT;
      div_c = 1'b1;
    end
  end

  logic [2:0]                          s4_rel;
  logic                                s4_div;
  logic signed [CW-1:0]                s4_ptx, s4_pty;
  logic signed [XW-1:0]                s4_den;
  logic signed [spic_pkg::HPX_W-1:0]   s4_hx1, s4_hy1;
  logic signed [spic_pkg::HPD_W-1:0]   s4_hx2, s4_hy2;

  always_ff @(posedge clk) begin
    if (en[S_CLASS]) begin
      s4_rel <= rel_c;
      s4_div <= div_c;
      s4_ptx <= ptx_c;
      s4_pty <= pty_c;
      s4_den <= s3_den;
      s4_hx1 <= spic_pkg::HPX_W'(s3_den) * spic_pkg::HPX_W'(s3_asx);
      s4_hy1 <= spic_pkg::HPX_W'(s3_den) * spic_pkg::HPX_W'(s3_asy);
      s4_hx2 <= spic_pkg::HPD_W'(s3_na) * spic_pkg::HPD_W'(s3_ax);
      s4_hy2 <= spic_pkg::HPD_W'(s3_na) * spic_pkg::HPD_W'(s3_ay);
    end
  end

  // ---------------- stage 5: numerators ----------------
  logic [2:0]           s5_rel;
  logic                 s5_div;
  logic signed [CW-1:0] s5_ptx, s5_pty;
  logic signed [XW-1:0] s5_den;
  logic signed [NW-1:0] s5_numx, s5_numy;

  always_ff @(posedge clk) begin
    if (en[S_SUM]) begin
      s5_rel  <= s4_rel;
      s5_div  <= s4_div;
      s5_ptx  <= s4_ptx;
      s5_pty  <= s4_pty;
      s5_den  <= s4_den;
      s5_numx <= NW'(s4_hx1) + NW'(s4_hx2);
      s5_numy <= NW'(s4_hy1) + NW'(s4_hy2);
    end
  end

  // ---------------- stage 6 and divider ----------------
  // index 0 is the magnitude stage; index j+1 follows quotient bit QW-1-j
  logic [NW-1:0]        dv_remx [QW+1];
  logic [NW-1:0]        dv_remy [QW+1];
  logic [QW-1:0]        dv_qx   [QW+1];
  logic [QW-1:0]        dv_qy   [QW+1];
  logic                 dv_negx [QW+1];
  logic                 dv_negy [QW+1];
  logic [XW-1:0]        dv_dabs [QW+1];
  logic [2:0]           dv_rel  [QW+1];
  logic                 dv_div  [QW+1];
  logic signed [CW-1:0] dv_ptx  [QW+1];
  logic signed [CW-1:0] dv_pty  [QW+1];

  always_ff @(posedge clk) begin
    if (en[S_ABS]) begin
      dv_remx[0] <= s5_numx[NW-1] ? NW'(-s5_numx) : NW'(s5_numx);
      dv_remy[0] <= s5_numy[NW-1] ? NW'(-s5_numy) : NW'(s5_numy);
      dv_qx[0]   <= '0;
      dv_qy[0]   <= '0;
      dv_negx[0] <= s5_numx[NW-1] ^ s5_den[XW-1];
      dv_negy[0] <= s5_numy[NW-1] ^ s5_den[XW-1];
      dv_dabs[0] <= spic_pkg::mag_c(s5_den);
      dv_rel[0]  <= s5_rel;
      dv_div[0]  <= s5_div;
      dv_ptx[0]  <= s5_ptx;
      dv_pty[0]  <= s5_pty;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [NW:0] dsh;
    logic [NW:0] trial_x, trial_y;

    assign dsh     = (NW + 1)'(dv_dabs[j]) << SH;
    assign trial_x = {1'b0, dv_remx[j]} - dsh;
    assign trial_y = {1'b0, dv_remy[j]} - dsh;

    always_ff @(posedge clk) begin
      if (en[S_DIV+j]) begin
        dv_remx[j+1] <= trial_x[NW] ? dv_remx[j] : trial_x[NW-1:0];
        dv_remy[j+1] <= trial_y[NW] ? dv_remy[j] : trial_y[NW-1:0];
        dv_qx[j+1]   <= {dv_qx[j][QW-2:0], !trial_x[NW]};
        dv_qy[j+1]   <= {dv_qy[j][QW-2:0], !trial_y[NW]};
        dv_negx[j+1] <= dv_negx[j];
        dv_negy[j+1] <= dv_negy[j];
        dv_dabs[j+1] <= dv_dabs[j];
        dv_rel[j+1]  <= dv_rel[j];
        dv_div[j+1]  <= dv_div[j];
        dv_ptx[j+1]  <= dv_ptx[j];
        dv_pty[j+1]  <= dv_pty[j];
      end
    end
  end

  // ---------------- output register ----------------
  logic [QW-1:0] qsx, qsy;

  assign qsx = dv_negx[QW] ? QW'(~dv_qx[QW] + QW'(1)) : dv_qx[QW];
  assign qsy = dv_negy[QW] ? QW'(~dv_qy[QW] + QW'(1)) : dv_qy[QW];

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      res.relation <= dv_rel[QW];
      res.cross_x  <= dv_div[QW] ? qsx[CW-1:0] : dv_ptx[QW];
      res.cross_y  <= dv_div[QW] ? qsy[CW-1:0] : dv_pty[QW];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spic_checker.sv
// Port-level checker for the segment pair classifier, bound to the top level.
// Uses spic_pkg and segment_pair_intersection_classify_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_pair_intersection_classify_core_assert.svh"
module spic_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           seg_stall,
  input wire logic           res_valid,
  input wire logic           res_stall,
  input wire spic_pkg::res_t res
);

  `SPIC_ASSERT_NEXT(a_reset_empty, rst, !res_valid, "result valid right after reset")

  `SPIC_ASSERT_NEXT(a_res_hold, !rst && res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

  // any free slot at the output frees the input through the bubble chain
  `SPIC_ASSERT_NOW(a_accept_open, !res_valid || !res_stall, !seg_stall, "request stalled with output free")

  `SPIC_ASSERT_NOW(a_cross_zero, res_valid && res.relation != spic_pkg::REL_HIT, res.cross_x == '0 && res.cross_y == '0, "point not zero without a hit")

endmodule

bind segment_pair_intersection_classify_core spic_checker u_spic_checker (
  .clk       (clk),
  .rst       (rst),
  .seg_stall (seg_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
`default_nettype wire
